/* sv/hsvrgb_pkg.sv */
// Shared constants and types for the HSV to RGB pixel converter.
// Depends on nothing; every other file of the block but hsvrgb_rsp_if refers to it by scoped names.
package hsvrgb_pkg;

   localparam int HUE_BITS   = 9;
   localparam int FRAC_BITS  = 6;
   localparam int SECTOR_DEG = 60;

   typedef struct packed {
      logic prod_en;
      logic recip_en;
      logic rem_en;
      logic ceil_en;
   } hsvrgb_stage_en_type;

endpackage

/* sv/hsvrgb_req_if.sv */
// Request channel carrying one HSV pixel per beat with valid/ready handshake.
// Depends on hsvrgb_pkg for the hue width.
interface hsvrgb_req_if #(
   parameter int CHANNEL_BITS = 8
);

   logic                              valid;
   logic                              ready;
   logic [hsvrgb_pkg::HUE_BITS-1:0]   hue;
   logic [CHANNEL_BITS-1:0]           saturation;
   logic [CHANNEL_BITS-1:0]           brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink (input valid, input hue, input saturation, input brightness,
                 output ready);

endinterface

/* sv/hsvrgb_rsp_if.sv */
// Response channel carrying one RGB pixel per beat with valid/ready handshake.
// Stands alone; the channel width follows CHANNEL_BITS.
interface hsvrgb_rsp_if #(
   parameter int CHANNEL_BITS = 8
);

   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red;
   logic [CHANNEL_BITS-1:0] green;
   logic [CHANNEL_BITS-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);

endinterface

/* sv/hsvrgb_frac_ceil.sv */
// Four-stage unit computing ceil((u*M + w) * k / (60*M)) for M = 2^CHANNEL_BITS - 1.
// The division by sixty uses a constant reciprocal; depends on hsvrgb_pkg.
module hsvrgb_frac_ceil #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                              clock,
   input  hsvrgb_pkg::hsvrgb_stage_en_type   stage_en,
   input  logic [CHANNEL_BITS-1:0]           quot,
   input  logic [CHANNEL_BITS-1:0]           rem,
   input  logic [hsvrgb_pkg::FRAC_BITS-1:0]  weight,
   output logic [CHANNEL_BITS-1:0]           ceil_out
);

   localparam int N     = CHANNEL_BITS;
   localparam int FB    = hsvrgb_pkg::FRAC_BITS;
   localparam int XB    = N + FB;
   localparam int YB    = XB + 1;
   localparam int SH    = XB + FB;
   localparam int RB    = XB + 1;
   localparam int M_INT = (1 << N) - 1;
   localparam logic [RB-1:0] RECIP =
      RB'(((64'd1 << SH) + 64'(hsvrgb_pkg::SECTOR_DEG) - 64'd1) /
          64'(hsvrgb_pkg::SECTOR_DEG));
   localparam logic [XB-1:0] DEG_X = XB'(hsvrgb_pkg::SECTOR_DEG);
   localparam logic [YB-1:0] LIMIT = YB'(hsvrgb_pkg::SECTOR_DEG * M_INT);

   logic [XB-1:0]    x_ff;
   logic [XB-1:0]    wk_ff;
   logic [XB+RB-1:0] prod_ff;
   logic [XB-1:0]    x_b_ff;
   logic [XB-1:0]    wk_b_ff;
   logic [N-1:0]     a_ff;
   logic [FB-1:0]    c_ff;
   logic [XB-1:0]    wk_c_ff;
   logic [N-1:0]     ceil_ff;

   logic [N-1:0]     a_in;
   logic [XB-1:0]    rem_full;
   logic [YB-1:0]    y_val;
   logic [1:0]       step;
   logic [N:0]       ceil_sum;

   assign a_in     = prod_ff[SH +: N];
   assign rem_full = x_b_ff - XB'(a_in) * DEG_X;

   assign y_val    = (YB'(c_ff) << N) - YB'(c_ff) + YB'(wk_c_ff);
   assign step     = (y_val == '0) ? 2'd0 : ((y_val <= LIMIT) ? 2'd1 : 2'd2);
   assign ceil_sum = {1'b0, a_ff} + (N+1)'(step);

   always_ff @(posedge clock) begin
      if (stage_en.prod_en) begin
         x_ff  <= XB'(quot) * XB'(weight);
         wk_ff <= XB'(rem) * XB'(weight);
      end
      if (stage_en.recip_en) begin
         prod_ff <= (XB+RB)'(x_ff) * (XB+RB)'(RECIP);
         x_b_ff  <= x_ff;
         wk_b_ff <= wk_ff;
      end
      if (stage_en.rem_en) begin
         a_ff    <= a_in;
         c_ff    <= rem_full[FB-1:0];
         wk_c_ff <= wk_b_ff;
      end
      if (stage_en.ceil_en) begin
         ceil_ff <= ceil_sum[N-1:0];
      end
   end

   assign ceil_out = ceil_ff;

endmodule

/* sv/hsv_to_rgb_converter_top.sv */
// Top level of the HSV to RGB pixel converter: hue split, products, routing and output buffer.
// Depends on hsvrgb_pkg, hsvrgb_req_if, hsvrgb_rsp_if and hsvrgb_frac_ceil.
//
// Usage: HSV pixels arrive on req_chan (hue in degrees, saturation and brightness as
// fractions of full scale) and RGB pixels leave on rsp_chan, one result beat for every
// request beat and in the same order. The block holds no state between pixels.
// Throughput is one pixel per clock cycle while the receiver takes results. The edge that
// accepts a request beat loads the first of six pipeline stages (hue split and V*S
// product, fold by full scale, two small products, reciprocal multiply by 1/60,
// remainder, rounding), and the output register follows the sixth.
// A hue of 360 or more has 360 taken off once.
// Synchronous reset empties the pipeline and the output buffer; nothing else needs it.
// When the receiver stalls, a skid register takes one more result and the pipeline
// closes its bubbles, so req_chan.ready stays high until every stage is full.
module hsv_to_rgb_converter_top #(
   parameter int CHANNEL_BITS = 8
) (
   input logic          clock,
   input logic          reset,
   hsvrgb_req_if.sink   req_chan,
   hsvrgb_rsp_if.source rsp_chan
);

   localparam int N      = CHANNEL_BITS;
   localparam int FB     = hsvrgb_pkg::FRAC_BITS;
   localparam int HB     = hsvrgb_pkg::HUE_BITS;
   localparam int STAGES = 6;
   localparam int M_INT  = (1 << N) - 1;

   localparam logic [HB-1:0] TURN_DEG = HB'(360);
   localparam logic [HB-1:0] DEG_1    = HB'(hsvrgb_pkg::SECTOR_DEG);
   localparam logic [HB-1:0] DEG_2    = HB'(2 * hsvrgb_pkg::SECTOR_DEG);
   localparam logic [HB-1:0] DEG_3    = HB'(3 * hsvrgb_pkg::SECTOR_DEG);
   localparam logic [HB-1:0] DEG_4    = HB'(4 * hsvrgb_pkg::SECTOR_DEG);
   localparam logic [HB-1:0] DEG_5    = HB'(5 * hsvrgb_pkg::SECTOR_DEG);
   localparam logic [FB-1:0] DEG_F    = FB'(hsvrgb_pkg::SECTOR_DEG);
   localparam logic [N:0]    FULL_X   = (N+1)'(M_INT);
   localparam logic [N:0]    FULL_X2  = (N+1)'(2 * M_INT);

   localparam logic [2:0] SEC_RED_YEL = 3'd0;
   localparam logic [2:0] SEC_YEL_GRN = 3'd1;
   localparam logic [2:0] SEC_GRN_CYA = 3'd2;
   localparam logic [2:0] SEC_CYA_BLU = 3'd3;
   localparam logic [2:0] SEC_BLU_MAG = 3'd4;
   localparam logic [2:0] SEC_MAG_RED = 3'd5;

   typedef struct packed {
      logic [N-1:0] bright;
      logic [2:0]   sector;
      logic [N-1:0] ceil_p;
   } carry_type;

   typedef struct packed {
      logic [N-1:0] red;
      logic [N-1:0] green;
      logic [N-1:0] blue;
   } rgb_type;

   logic [STAGES:1] valid_ff;
   logic [STAGES:1] valid_in;
   logic [STAGES:1] stage_en;
   logic            out_valid_ff;
   logic            skid_valid_ff;
   logic            pipe_fire;
   logic            req_fire;

   logic [HB-1:0]   hue_wrap;
   logic [2:0]      sector_in;
   logic [HB-1:0]   base_in;
   logic [HB-1:0]   rem_full;
   logic [FB-1:0]   rem_in;
   logic [2*N-1:0]  vs_in;

   logic [FB-1:0]   s1_rem_ff;
   logic [FB-1:0]   s1_remc_ff;
   logic [2*N-1:0]  s1_vs_ff;
   logic [N-1:0]    s1_bright_ff;
   logic [2:0]      s1_sector_ff;

   logic [N:0]      fold_sum;
   logic [N:0]      u_in;
   logic [N:0]      w_in;
   logic [N:0]      ceil_p_sum;

   logic [N-1:0]    s2_u_ff;
   logic [N-1:0]    s2_w_ff;
   logic [FB-1:0]   s2_rem_ff;
   logic [FB-1:0]   s2_remc_ff;
   carry_type       carry_ff [2:STAGES];

   hsvrgb_pkg::hsvrgb_stage_en_type frac_en;
   logic [N-1:0]    ceil_q;
   logic [N-1:0]    ceil_t;
   logic [N-1:0]    chan_p;
   logic [N-1:0]    chan_q;
   logic [N-1:0]    chan_t;
   logic [N-1:0]    chan_v;
   rgb_type         route;
   rgb_type         out_data_ff;
   rgb_type         skid_data_ff;

   // Stage enables: a stage loads when it is empty or its contents move on.
   always_comb begin
      stage_en[STAGES] = !valid_ff[STAGES] || !skid_valid_ff;
      for (int i = STAGES - 1; i >= 1; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   assign req_chan.ready = stage_en[1];
   assign req_fire       = req_chan.valid && stage_en[1];
   assign pipe_fire      = valid_ff[STAGES] && !skid_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (stage_en[1]) begin
         valid_in[1] = req_fire;
      end
      for (int i = 2; i <= STAGES; i++) begin
         if (stage_en[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   // Hue split into sector and remainder.
   assign hue_wrap = (req_chan.hue >= TURN_DEG) ? req_chan.hue - TURN_DEG : req_chan.hue;

   always_comb begin
      if (hue_wrap < DEG_1) begin
         sector_in = SEC_RED_YEL;
         base_in   = '0;
      end else if (hue_wrap < DEG_2) begin
         sector_in = SEC_YEL_GRN;
         base_in   = DEG_1;
      end else if (hue_wrap < DEG_3) begin
         sector_in = SEC_GRN_CYA;
         base_in   = DEG_2;
      end else if (hue_wrap < DEG_4) begin
         sector_in = SEC_CYA_BLU;
         base_in   = DEG_3;
      end else if (hue_wrap < DEG_5) begin
         sector_in = SEC_BLU_MAG;
         base_in   = DEG_4;
      end else begin
         sector_in = SEC_MAG_RED;
         base_in   = DEG_5;
      end
   end

   assign rem_full = hue_wrap - base_in;
   assign rem_in   = rem_full[FB-1:0];
   assign vs_in    = (2*N)'(req_chan.saturation) * (2*N)'(req_chan.brightness);

   // Fold V*S by the full scale: V*S = u*M + w with w below M.
   assign fold_sum = {1'b0, s1_vs_ff[2*N-1:N]} + {1'b0, s1_vs_ff[N-1:0]};

   always_comb begin
      if (fold_sum >= FULL_X2) begin
         u_in = {1'b0, s1_vs_ff[2*N-1:N]} + (N+1)'(2);
         w_in = fold_sum - FULL_X2;
      end else if (fold_sum >= FULL_X) begin
         u_in = {1'b0, s1_vs_ff[2*N-1:N]} + (N+1)'(1);
         w_in = fold_sum - FULL_X;
      end else begin
         u_in = {1'b0, s1_vs_ff[2*N-1:N]};
         w_in = fold_sum;
      end
   end

   assign ceil_p_sum = u_in + (N+1)'(w_in != '0);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s1_rem_ff    <= rem_in;
         s1_remc_ff   <= DEG_F - rem_in;
         s1_vs_ff     <= vs_in;
         s1_bright_ff <= req_chan.brightness;
         s1_sector_ff <= sector_in;
      end
      if (stage_en[2]) begin
         s2_u_ff            <= u_in[N-1:0];
         s2_w_ff            <= w_in[N-1:0];
         s2_rem_ff          <= s1_rem_ff;
         s2_remc_ff         <= s1_remc_ff;
         carry_ff[2].bright <= s1_bright_ff;
         carry_ff[2].sector <= s1_sector_ff;
         carry_ff[2].ceil_p <= ceil_p_sum[N-1:0];
      end
      for (int i = 3; i <= STAGES; i++) begin
         if (stage_en[i]) begin
            carry_ff[i] <= carry_ff[i-1];
         end
      end
   end

   assign frac_en.prod_en  = stage_en[3];
   assign frac_en.recip_en = stage_en[4];
   assign frac_en.rem_en   = stage_en[5];
   assign frac_en.ceil_en  = stage_en[6];

   hsvrgb_frac_ceil #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_frac_q (
      .clock    (clock),
      .stage_en (frac_en),
      .quot     (s2_u_ff),
      .rem      (s2_w_ff),
      .weight   (s2_rem_ff),
      .ceil_out (ceil_q)
   );

   hsvrgb_frac_ceil #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_frac_t (
      .clock    (clock),
      .stage_en (frac_en),
      .quot     (s2_u_ff),
      .rem      (s2_w_ff),
      .weight   (s2_remc_ff),
      .ceil_out (ceil_t)
   );

   // Zero saturation gives zero correction terms, so all channels fall out as V.
   assign chan_v = carry_ff[STAGES].bright;
   assign chan_p = chan_v - carry_ff[STAGES].ceil_p;
   assign chan_q = chan_v - ceil_q;
   assign chan_t = chan_v - ceil_t;

   always_comb begin
      case (carry_ff[STAGES].sector)
         SEC_RED_YEL: begin
            route = '{red: chan_v, green: chan_t, blue: chan_p};
         end
         SEC_YEL_GRN: begin
            route = '{red: chan_q, green: chan_v, blue: chan_p};
         end
         SEC_GRN_CYA: begin
            route = '{red: chan_p, green: chan_v, blue: chan_t};
         end
         SEC_CYA_BLU: begin
            route = '{red: chan_p, green: chan_q, blue: chan_v};
         end
         SEC_BLU_MAG: begin
            route = '{red: chan_t, green: chan_p, blue: chan_v};
         end
         default: begin
            route = '{red: chan_v, green: chan_p, blue: chan_q};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rsp_chan.ready || !out_valid_ff) begin
            out_valid_ff  <= skid_valid_ff || pipe_fire;
            skid_valid_ff <= 1'b0;
         end else if (pipe_fire) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_chan.ready || !out_valid_ff) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : route;
      end else if (pipe_fire) begin
         skid_data_ff <= route;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.red   = out_data_ff.red;
   assign rsp_chan.green = out_data_ff.green;
   assign rsp_chan.blue  = out_data_ff.blue;

`ifndef ASSERT_OFF
   a_skid_needs_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid register holds a beat while the output register is empty.");

   a_skid_on_stall : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_chan.ready))
      else $error("Skid register filled without a stalled output beat.");

   a_req_enters : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> valid_ff[1])
      else $error("Accepted request beat did not reach the first stage.");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> (!out_valid_ff && !skid_valid_ff && valid_ff == '0))
      else $error("Pipeline not empty after reset.");
`endif

endmodule
